// File: design/dbrm_pkg.sv
`default_nettype none
package dbrm_pkg;
  localparam int TableEntries = 256;
  localparam int QueueSlots = 512;
  localparam int IndexBits = 16;
  localparam int PosBits = $clog2(TableEntries);
  localparam int CountBits = $clog2(TableEntries + 1);
  localparam int SlotBits = $clog2(QueueSlots);
  localparam int SlotsBits = $clog2(QueueSlots + 1);
  localparam int CfgBits = 16;

  localparam logic [2:0] CMD_LOAD = 3'd0;
  localparam logic [2:0] CMD_RET_HANDLE = 3'd1;
  localparam logic [2:0] CMD_RET_INDEX = 3'd2;
  localparam logic [2:0] CMD_PUSH = 3'd3;
  localparam logic [2:0] CMD_POP = 3'd4;

  localparam logic [2:0] ST_LOADED = 3'd0;
  localparam logic [2:0] ST_QUEUED = 3'd1;
  localparam logic [2:0] ST_RX_FOUND = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_FULL = 3'd4;
  localparam logic [2:0] ST_POPPED = 3'd5;
  localparam logic [2:0] ST_EMPTY = 3'd6;

  localparam logic [2:0] REG_TX_COUNT = 3'd0;
  localparam logic [2:0] REG_TX_BASE = 3'd1;
  localparam logic [2:0] REG_RX_COUNT = 3'd2;
  localparam logic [2:0] REG_RX_BASE = 3'd3;
  localparam logic [2:0] REG_QUEUE_SLOTS = 3'd4;

  // controller -> datapath
  typedef struct packed {
    logic capture;     // latch the command fields
    logic load_write;  // write table entry
    logic scan_start;  // clear scan position, issue first read
    logic scan_step;   // compare current entry, advance
    logic scan_rx;     // 0 transmit table, 1 receive table
    logic push;        // write ring at write pointer
    logic pop_read;    // issue ring read
    logic pop_done;    // advance read pointer
    logic finish;      // drive the result strobe
    logic [2:0] status;
    logic use_found;   // buffer_index from scan hit, else command index
    logic use_pop;     // buffer_index from ring read data
    logic zero_index;
  } dbrm_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [2:0] command;
    logic scan_hit;
    logic scan_end;
    logic full;
    logic empty;
    logic in_tx;
    logic in_rx;
  } dbrm_stat_t;
endpackage
`default_nettype wire

// File: design/dbrm_datapath.sv
`default_nettype none
module dbrm_datapath (
  input  wire logic clk,
  input  wire logic rst,
  input  wire dbrm_pkg::dbrm_cmd_t cmd,
  output dbrm_pkg::dbrm_stat_t stat,
  input  wire logic cfg_write,
  input  wire logic [2:0] cfg_index,
  input  wire logic [dbrm_pkg::CfgBits-1:0] cfg_data,
  input  wire logic [2:0] command,
  input  wire logic list_select,
  input  wire logic [7:0] position,
  input  wire logic [63:0] handle,
  input  wire logic [15:0] buffer_index_in,
  output logic done,
  output logic [2:0] status,
  output logic [15:0] buffer_index,
  output logic queue_not_empty
);
  import dbrm_pkg::*;

  logic [63:0] tx_mem [TableEntries];
  logic [63:0] rx_mem [TableEntries];
  logic [IndexBits-1:0] q_mem [QueueSlots];

  logic [CountBits-1:0] tx_count, rx_count;
  logic [IndexBits-1:0] tx_base, rx_base;
  logic [SlotsBits-1:0] queue_slots;
  logic [SlotBits-1:0] read_pointer, write_pointer;

  logic [2:0] c_cmd;
  logic c_sel;
  logic [7:0] c_pos;
  logic [63:0] c_handle;
  logic [IndexBits-1:0] c_idx;

  logic [CountBits-1:0] scan_pos;   // address issued
  logic [CountBits-1:0] cmp_pos;    // entry whose data is in tx_rd / rx_rd
  logic [PosBits-1:0] rd_addr;
  logic [63:0] tx_rd, rx_rd;
  logic [IndexBits-1:0] q_rd;
  logic hit;

  logic [SlotBits-1:0] wp_next, rp_next;
  logic [CountBits-1:0] cnt_sel;
  logic [IndexBits-1:0] off_tx, off_rx;
  logic [CfgBits-1:0] cfg_cnt_sat;
  logic [SlotsBits-1:0] cfg_slots;

  function automatic logic [SlotBits-1:0] ring_next(input logic [SlotBits-1:0] p,
                                                    input logic [SlotsBits-1:0] n);
    logic [SlotsBits-1:0] q;
    q = SlotsBits'(p) + 1'b1;
    return (q >= n) ? '0 : q[SlotBits-1:0];
  endfunction

  // buffer index of the entry being compared
  function automatic logic [IndexBits-1:0] hit_pos_idx();
    return (c_sel ? rx_base : tx_base) + IndexBits'(cmp_pos[PosBits-1:0]);
  endfunction

  always_comb begin
    wp_next = ring_next(write_pointer, queue_slots);
    rp_next = ring_next(read_pointer, queue_slots);
    cnt_sel = c_sel ? rx_count : tx_count;
    off_tx = c_idx - tx_base;
    off_rx = c_idx - rx_base;
    rd_addr = cmd.scan_start ? '0 : scan_pos[PosBits-1:0];
    cfg_cnt_sat = (cfg_data[8:0] > 9'(TableEntries)) ? CfgBits'(TableEntries)
                                                     : CfgBits'(cfg_data[8:0]);
    if (cfg_data[9:0] < 10'd2) cfg_slots = SlotsBits'(2);
    else if (cfg_data[9:0] > 10'(QueueSlots)) cfg_slots = SlotsBits'(QueueSlots);
    else cfg_slots = SlotsBits'(cfg_data[9:0]);
    stat.command = c_cmd;
    stat.scan_hit = hit;
    stat.scan_end = (cmp_pos >= cnt_sel);
    stat.full = (wp_next == read_pointer);
    stat.empty = (read_pointer == write_pointer);
    stat.in_tx = (c_idx >= tx_base) && (CountBits'(off_tx) < tx_count)
                 && ((off_tx >> CountBits) == 0);
    stat.in_rx = (c_idx >= rx_base) && (CountBits'(off_rx) < rx_count)
                 && ((off_rx >> CountBits) == 0);
  end

  // hit against registered read data of the entry at cmp_pos
  always_comb begin
    hit = (cmp_pos < cnt_sel) && ((c_sel ? rx_rd : tx_rd) == c_handle);
  end

  always_ff @(posedge clk) begin
    tx_rd <= tx_mem[rd_addr];
    rx_rd <= rx_mem[rd_addr];
    if (cmd.load_write && !c_sel) tx_mem[c_pos] <= c_handle;
    if (cmd.load_write && c_sel) rx_mem[c_pos] <= c_handle;
  end

  always_ff @(posedge clk) begin
    if (cmd.pop_read) q_rd <= q_mem[read_pointer];
    if (cmd.push) q_mem[write_pointer] <= cmd.use_found ? hit_pos_idx() : c_idx;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      c_cmd <= command;
      c_sel <= list_select;
      c_pos <= position;
      c_handle <= handle;
      c_idx <= buffer_index_in;
    end
    if (cmd.scan_start) begin
      c_sel <= cmd.scan_rx;
      scan_pos <= CountBits'(1);
      cmp_pos <= '0;
    end else if (cmd.scan_step) begin
      scan_pos <= scan_pos + 1'b1;
      cmp_pos <= cmp_pos + 1'b1;
    end
    if (cmd.finish) begin
      status <= cmd.status;
      if (cmd.zero_index) buffer_index <= '0;
      else if (cmd.use_pop) buffer_index <= q_rd;
      else if (cmd.use_found) buffer_index <= hit_pos_idx();
      else buffer_index <= c_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_count <= '0; tx_base <= '0; rx_count <= '0; rx_base <= '0;
      queue_slots <= SlotsBits'(QueueSlots);
      read_pointer <= '0; write_pointer <= '0;
      done <= 1'b0; queue_not_empty <= 1'b0;
    end else begin
      done <= cmd.finish;
      if (cmd.push) write_pointer <= wp_next;
      if (cmd.pop_done) read_pointer <= rp_next;
      if (cmd.finish)
        queue_not_empty <= (cmd.push ? wp_next : write_pointer)
                           != (cmd.pop_done ? rp_next : read_pointer);
      if (cfg_write) begin
        unique case (cfg_index)
          REG_TX_COUNT: tx_count <= CountBits'(cfg_cnt_sat);
          REG_TX_BASE: tx_base <= cfg_data[IndexBits-1:0];
          REG_RX_COUNT: rx_count <= CountBits'(cfg_cnt_sat);
          REG_RX_BASE: rx_base <= cfg_data[IndexBits-1:0];
          REG_QUEUE_SLOTS: begin
            queue_slots <= cfg_slots;
            read_pointer <= '0;
            write_pointer <= '0;
          end
          default: ;
        endcase
      end
    end
  end
endmodule
`default_nettype wire

// File: design/dbrm_controller.sv
`default_nettype none
module dbrm_controller (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic busy,
  input  wire dbrm_pkg::dbrm_stat_t stat,
  output dbrm_pkg::dbrm_cmd_t cmd
);
  import dbrm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_SCAN_TX, S_SCAN_RX, S_POP
  } state_t;
  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (start) begin state <= S_DECODE; busy <= 1'b1; end
        S_DECODE: begin
          if (stat.command == CMD_RET_HANDLE) state <= S_SCAN_TX;
          else if (stat.command == CMD_POP && !stat.empty) state <= S_POP;
          else begin state <= S_IDLE; busy <= 1'b0; end
        end
        S_SCAN_TX: if (stat.scan_hit) begin
          state <= S_IDLE; busy <= 1'b0;
        end else if (stat.scan_end) state <= S_SCAN_RX;
        S_SCAN_RX: if (stat.scan_hit || stat.scan_end) begin
          state <= S_IDLE; busy <= 1'b0;
        end
        S_POP: begin state <= S_IDLE; busy <= 1'b0; end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd = '0;
    cmd.status = ST_NOT_FOUND;
    unique case (state)
      S_IDLE: cmd.capture = start;
      S_DECODE: begin
        unique case (stat.command)
          CMD_LOAD: begin
            cmd.load_write = 1'b1; cmd.finish = 1'b1; cmd.status = ST_LOADED;
            cmd.zero_index = 1'b1;
          end
          CMD_RET_HANDLE: begin cmd.scan_start = 1'b1; cmd.scan_rx = 1'b0; end
          CMD_RET_INDEX: begin
            cmd.finish = 1'b1;
            if (stat.in_tx) begin
              cmd.status = stat.full ? ST_FULL : ST_QUEUED;
              cmd.push = !stat.full;
            end else if (stat.in_rx) cmd.status = ST_RX_FOUND;
            else cmd.zero_index = 1'b1;
          end
          CMD_PUSH: begin
            cmd.finish = 1'b1;
            cmd.status = stat.full ? ST_FULL : ST_QUEUED;
            cmd.push = !stat.full;
          end
          CMD_POP: begin
            if (stat.empty) begin
              cmd.finish = 1'b1; cmd.status = ST_EMPTY; cmd.zero_index = 1'b1;
            end else cmd.pop_read = 1'b1;
          end
          default: begin cmd.finish = 1'b1; cmd.zero_index = 1'b1; end
        endcase
      end
      S_SCAN_TX: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_hit) begin
          cmd.finish = 1'b1; cmd.use_found = 1'b1;
          cmd.status = stat.full ? ST_FULL : ST_QUEUED;
          cmd.push = !stat.full;
        end else if (stat.scan_end) begin
          cmd.scan_step = 1'b0; cmd.scan_start = 1'b1; cmd.scan_rx = 1'b1;
        end
      end
      S_SCAN_RX: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_hit) begin
          cmd.finish = 1'b1; cmd.use_found = 1'b1; cmd.status = ST_RX_FOUND;
        end else if (stat.scan_end) begin
          cmd.finish = 1'b1; cmd.zero_index = 1'b1;
        end
      end
      S_POP: begin
        cmd.finish = 1'b1; cmd.use_pop = 1'b1; cmd.pop_done = 1'b1;
        cmd.status = ST_POPPED;
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// File: design/dma_buffer_return_manager_unit.sv
`default_nettype none
// Channel   | Handshake          | Payload
// command   | start / busy       | command, list_select, position, handle, buffer_index_in
// result    | done (one cycle)   | status, buffer_index, queue_not_empty
// config    | cfg_write          | cfg_index, cfg_data
// A transaction is taken when start is high and busy is low; busy rises on the next edge.
// load, return_by_index, push_tx and an empty pop_tx finish in decode; pop_tx then pops the ring.
// return_by_handle scans the tables one entry a cycle through the table read port,
// transmit table first, then receive table; a transmit hit ends the scan early.
// Reset (rst, synchronous) clears counts, bases and ring pointers; tables hold garbage.
// The receiver cannot stall: done is high for one cycle and the result must be taken.
module dma_buffer_return_manager_unit (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic busy,
  input  wire logic cfg_write,
  input  wire logic [2:0] cfg_index,
  input  wire logic [dbrm_pkg::CfgBits-1:0] cfg_data,
  input  wire logic [2:0] command,
  input  wire logic list_select,
  input  wire logic [7:0] position,
  input  wire logic [63:0] handle,
  input  wire logic [15:0] buffer_index_in,
  output logic done,
  output logic [2:0] status,
  output logic [15:0] buffer_index,
  output logic queue_not_empty
);
  import dbrm_pkg::*;

  dbrm_cmd_t cmd;
  dbrm_stat_t stat;

  // sequence each transaction
  dbrm_controller u_ctrl (
    .clk, .rst, .start, .busy, .stat, .cmd
  );

  // tables, ring and result registers
  dbrm_datapath u_dp (
    .clk, .rst, .cmd, .stat, .cfg_write, .cfg_index, .cfg_data,
    .command, .list_select, .position, .handle, .buffer_index_in,
    .done, .status, .buffer_index, .queue_not_empty
  );
endmodule
`default_nettype wire
